// ===== hw/rtl/handle_table_allocator_defines.svh =====
// assertion helpers for the handle table allocator
`ifndef HANDLE_TABLE_ALLOCATOR_DEFINES_SVH
`define HANDLE_TABLE_ALLOCATOR_DEFINES_SVH

// condition implies consequence in the same cycle
`define HTA_ASSERT_NOW(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define HTA_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/hta_pkg.sv =====
package hta_pkg;

  // table geometry; GROUP_SIZE is a power of two
  localparam int NUM_HANDLES  = 1024;
  localparam int GROUP_SIZE   = 32;
  localparam int SOURCE_WIDTH = 32;
  localparam int NUM_GROUPS   = (NUM_HANDLES + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam int HANDLE_BITS = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
  localparam int GROUP_BITS  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int LANE_BITS   = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

  // operation codes
  localparam logic [1:0] OP_TAKE = 2'd0;
  localparam logic [1:0] OP_GIVE = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;
  localparam logic [1:0] OP_GET  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef logic [GROUP_SIZE-1:0]   word_t;
  typedef logic [SOURCE_WIDTH-1:0] source_t;

  // lanes past the end of the table count as in use
  function automatic word_t pad_mask(input logic [GROUP_BITS-1:0] grp);
    word_t m;
    m = '0;
    for (int k = 0; k < GROUP_SIZE; k++) begin
      m[k] = (int'(grp) * GROUP_SIZE + k) >= NUM_HANDLES;
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/handle_table_allocator.sv =====
// channel   handshake             fields
// input     in_valid, in_ready    op, handle, source_value
// output    out_valid, out_ready  result_handle, result_source, status
//
// each item has a read step for the in-use bitmap row and source memory,
// then a modify step that searches the row, modifies it and writes it back.
// the next item is taken while the previous result waits in the output
// register; an item stalls in its modify step until that register is free.
// reset marks every group free and clears the row valid bits at once, no sweep.
`include "handle_table_allocator_defines.svh"

module handle_table_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] handle,
  input  logic [31:0] source_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result_handle,
  output logic [31:0] result_source,
  output logic [1:0]  status
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  localparam int GB = hta_pkg::GROUP_BITS;
  localparam int LB = hta_pkg::LANE_BITS;
  localparam int HB = hta_pkg::HANDLE_BITS;

  // memories
  hta_pkg::word_t   map_mem [hta_pkg::NUM_GROUPS];
  hta_pkg::source_t src_mem [hta_pkg::NUM_HANDLES];

  logic                         state;
  logic [hta_pkg::NUM_GROUPS-1:0] group_has_free;
  logic [hta_pkg::NUM_GROUPS-1:0] row_valid;

  // captured item
  logic [1:0]       op_q;
  logic [15:0]      handle_q;
  hta_pkg::source_t value_q;
  logic [GB-1:0]    grp_q;
  logic             any_q;
  logic             in_range_q;
  logic             row_valid_q;
  hta_pkg::word_t   map_rdata;
  hta_pkg::source_t src_rdata;

  logic             accept;
  logic             go;
  logic [GB-1:0]    free_grp;
  logic             any_free;
  logic [GB-1:0]    rd_grp;
  logic             in_range;
  logic [HB-1:0]    in_idx;

  hta_pkg::word_t   word;
  hta_pkg::word_t   word_next;
  logic [LB-1:0]    free_lane;
  logic [LB-1:0]    hlane;
  logic             hbit;
  logic             map_we;
  logic             src_we;
  logic [HB-1:0]    src_waddr;
  hta_pkg::source_t src_wdata;
  logic             ghf_set;
  logic             ghf_val;
  logic [HB-1:0]    take_idx;
  logic [15:0]      res_handle_next;
  logic [31:0]      res_source_next;
  logic [1:0]       status_next;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign go       = (state == ST_EXEC) && (!out_valid || out_ready);

  // lowest group that still has a free handle
  always_comb begin
    free_grp = '0;
    any_free = 1'b0;
    for (int g = hta_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
      if (group_has_free[g]) begin
        free_grp = GB'(g);
        any_free = 1'b1;
      end
    end
  end

  assign in_range = 32'(handle) < hta_pkg::NUM_HANDLES;
  assign in_idx   = HB'(handle);
  assign rd_grp   = (op == hta_pkg::OP_TAKE) ? free_grp
                                             : GB'(handle / hta_pkg::GROUP_SIZE);

  // memory reads at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      map_rdata   <= map_mem[rd_grp];
      src_rdata   <= src_mem[in_idx];
      row_valid_q <= row_valid[rd_grp];
      op_q        <= op;
      handle_q    <= handle;
      value_q     <= hta_pkg::SOURCE_WIDTH'(source_value);
      grp_q       <= rd_grp;
      any_q       <= any_free;
      in_range_q  <= in_range;
    end
  end

  // row as seen by the search, lowest free lane
  always_comb begin
    word      = (row_valid_q ? map_rdata : '0) | hta_pkg::pad_mask(grp_q);
    free_lane = '0;
    for (int k = hta_pkg::GROUP_SIZE - 1; k >= 0; k--) begin
      if (!word[k]) begin
        free_lane = LB'(k);
      end
    end
  end

  assign hlane    = LB'(handle_q % hta_pkg::GROUP_SIZE);
  assign hbit     = word[hlane];
  assign take_idx = HB'(int'(grp_q) * hta_pkg::GROUP_SIZE + int'(free_lane));

  // modify step and result
  always_comb begin
    word_next       = word;
    map_we          = 1'b0;
    src_we          = 1'b0;
    src_waddr       = HB'(handle_q);
    src_wdata       = value_q;
    ghf_set         = 1'b0;
    ghf_val         = 1'b1;
    res_handle_next = handle_q;
    res_source_next = '0;
    status_next     = hta_pkg::ST_OK;
    case (op_q)
      hta_pkg::OP_TAKE: begin
        if (any_q) begin
          word_next[free_lane] = 1'b1;
          map_we          = 1'b1;
          src_we          = 1'b1;
          src_waddr       = take_idx;
          src_wdata       = '1;
          ghf_set         = 1'b1;
          ghf_val         = ~&word_next;
          res_handle_next = 16'(take_idx);
        end else begin
          status_next = hta_pkg::ST_FULL;
        end
      end
      hta_pkg::OP_GIVE: begin
        if (in_range_q && hbit) begin
          word_next[hlane] = 1'b0;
          map_we  = 1'b1;
          ghf_set = 1'b1;
          ghf_val = 1'b1;
        end else begin
          status_next = hta_pkg::ST_BAD;
        end
      end
      hta_pkg::OP_SET: begin
        if (in_range_q && hbit) begin
          src_we = 1'b1;
        end else begin
          status_next = hta_pkg::ST_BAD;
        end
      end
      hta_pkg::OP_GET: begin
        if (in_range_q && hbit) begin
          res_source_next = 32'(src_rdata);
        end else begin
          status_next = hta_pkg::ST_BAD;
        end
      end
      default: begin
        status_next = hta_pkg::ST_BAD;
      end
    endcase
  end

  // write back
  always_ff @(posedge clk) begin
    if (go && map_we) begin
      map_mem[grp_q] <= word_next;
    end
    if (go && src_we) begin
      src_mem[src_waddr] <= src_wdata;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      group_has_free <= '1;
      row_valid      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (go && ghf_set) begin
        group_has_free[grp_q] <= ghf_val;
      end
      if (go && map_we) begin
        row_valid[grp_q] <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (go) begin
      result_handle <= res_handle_next;
      result_source <= res_source_next;
      status        <= status_next;
    end
  end

  // checks
  `HTA_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == ST_EXEC, "item not in exec")
  `HTA_ASSERT_NOW(a_write_in_exec, clk, rst, map_we && go, state == ST_EXEC,
                  "bitmap write outside exec")
  `HTA_ASSERT_NOW(a_err_zero, clk, rst, out_valid && status != hta_pkg::ST_OK,
                  result_source == 32'd0, "error result with source word")
  `HTA_ASSERT_NEXT(a_go_valid, clk, rst, go, out_valid, "result lost")

endmodule

// ===== tb/handle_table_allocator_tb.sv =====
`timescale 1ns / 100ps

module handle_table_allocator_tb;

  localparam int RESET_CYCLES = 6;
  localparam int LONG_HOLD    = 48;
  localparam int QUIET_TAIL   = 100;
  localparam int DRAIN_CYCLES = 20;
  localparam int STUCK_LIMIT  = 2000;

  typedef struct packed {
    logic [1:0]  code;
    logic [15:0] hnd;
    logic [31:0] word;
  } cmd_t;

  typedef struct packed {
    logic [15:0] hnd;
    logic [31:0] src;
    logic [1:0]  st;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = hta_pkg::OP_TAKE;
  logic [15:0] handle = '0;
  logic [31:0] source_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] result_handle;
  logic [31:0] result_source;
  logic [1:0]  status;

  handle_table_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .handle        (handle),
    .source_value  (source_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_handle (result_handle),
    .result_source (result_source),
    .status        (status)
  );

  always #1 clk = ~clk;

  // commands waiting to be driven and replies waiting to come back
  cmd_t   queued_cmds[$];
  reply_t expected_replies[$];

  // predicted table contents
  bit               used_map[hta_pkg::NUM_HANDLES];
  hta_pkg::source_t bound_word[hta_pkg::NUM_HANDLES];
  bit               group_free[hta_pkg::NUM_GROUPS];

  // occupancy as seen while building the stimulus
  bit gen_used[hta_pkg::NUM_HANDLES];
  int gen_count;

  int n_in, n_out, errors, stuck;
  int n_grant, n_full, n_bad;
  int gap_left, stall_left, long_hold_left, holds_done;
  bit quiet;
  cmd_t next_cmd;
  reply_t want;

  // predict one reply and update the predicted table
  function automatic reply_t table_reply(input logic [1:0] c_op, input logic [15:0] c_hnd,
                                         input logic [31:0] c_word);
    reply_t r;
    int h, g;
    bit found;
    r.hnd = c_hnd;
    r.src = '0;
    r.st  = hta_pkg::ST_OK;
    found = 1'b0;
    if (c_op == hta_pkg::OP_TAKE) begin
      // summary picks the group, bitmap picks the lane
      for (g = 0; g < hta_pkg::NUM_GROUPS && !found; g++) begin
        if (group_free[g]) begin
          for (int k = 0; k < hta_pkg::GROUP_SIZE && !found; k++) begin
            h = g * hta_pkg::GROUP_SIZE + k;
            if (h < hta_pkg::NUM_HANDLES && !used_map[h]) begin
              found = 1'b1;
              r.hnd = 16'(h);
            end
          end
        end
      end
      if (found) begin
        used_map[r.hnd] = 1'b1;
        bound_word[r.hnd] = '1;
        g = int'(r.hnd) / hta_pkg::GROUP_SIZE;
        group_free[g] = 1'b0;
        for (int k = 0; k < hta_pkg::GROUP_SIZE; k++) begin
          h = g * hta_pkg::GROUP_SIZE + k;
          if (h < hta_pkg::NUM_HANDLES && !used_map[h]) group_free[g] = 1'b1;
        end
        n_grant++;
      end else begin
        r.st = hta_pkg::ST_FULL;
        n_full++;
      end
    end else if (int'(c_hnd) >= hta_pkg::NUM_HANDLES || !used_map[c_hnd]) begin
      r.st = hta_pkg::ST_BAD;
      n_bad++;
    end else if (c_op == hta_pkg::OP_GIVE) begin
      used_map[c_hnd] = 1'b0;
      group_free[int'(c_hnd) / hta_pkg::GROUP_SIZE] = 1'b1;
    end else if (c_op == hta_pkg::OP_SET) begin
      bound_word[c_hnd] = hta_pkg::source_t'(c_word);
    end else begin
      r.src = 32'(bound_word[c_hnd]);
    end
    return r;
  endfunction

  // queue a command and track which handles it leaves in use
  task automatic add_cmd(input logic [1:0] c_op, input int h, input logic [31:0] w);
    cmd_t c;
    bit done;
    c.code = c_op;
    c.hnd  = 16'(h);
    c.word = w;
    queued_cmds.push_back(c);
    done = 1'b0;
    if (c_op == hta_pkg::OP_TAKE) begin
      for (int i = 0; i < hta_pkg::NUM_HANDLES && !done; i++) begin
        if (!gen_used[i]) begin
          gen_used[i] = 1'b1;
          gen_count++;
          done = 1'b1;
        end
      end
    end else if (c_op == hta_pkg::OP_GIVE && h < hta_pkg::NUM_HANDLES && gen_used[h]) begin
      gen_used[h] = 1'b0;
      gen_count--;
    end
  endtask

  function automatic int pick_live();
    int start, h;
    start = $urandom_range(0, hta_pkg::NUM_HANDLES - 1);
    for (int i = 0; i < hta_pkg::NUM_HANDLES; i++) begin
      h = (start + i) % hta_pkg::NUM_HANDLES;
      if (gen_used[h]) return h;
    end
    return 0;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_noise_handle();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 65535);
      1:       return hta_pkg::NUM_HANDLES + $urandom_range(0, 7);
      2:       return $urandom_range(0, hta_pkg::NUM_HANDLES - 1);
      default: return 65535;
    endcase
  endfunction

  // one random command: take, give of a live handle, set/get of a live handle, or noise
  task automatic random_cmd(input int take_pct, input int give_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < take_pct) begin
      add_cmd(hta_pkg::OP_TAKE, $urandom_range(0, 65535), pick_word());
    end else if (gen_count == 0 || r >= 90) begin
      add_cmd(2'($urandom_range(0, 3)), pick_noise_handle(), pick_word());
    end else if (r < take_pct + give_pct) begin
      add_cmd(hta_pkg::OP_GIVE, pick_live(), pick_word());
    end else if (r[0]) begin
      add_cmd(hta_pkg::OP_SET, pick_live(), pick_word());
    end else begin
      add_cmd(hta_pkg::OP_GET, pick_live(), pick_word());
    end
  endtask

  // driver: next queued item goes out once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      n_in     <= 0;
      quiet    <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_replies.push_back(table_reply(op, handle, source_value));
        n_in <= n_in + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (queued_cmds.size() > 0) begin
          next_cmd = queued_cmds.pop_front();
          in_valid     <= 1'b1;
          op           <= next_cmd.code;
          handle       <= next_cmd.hnd;
          source_value <= next_cmd.word;
          if (!quiet && $urandom_range(0, 4) == 0) gap_left <= $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
      quiet <= queued_cmds.size() < QUIET_TAIL;
    end
  end

  // receiver: short random stalls plus two long hold-offs to back up the block
  always @(posedge clk) begin
    if (rst) begin
      out_ready      <= 1'b0;
      stall_left     <= 0;
      long_hold_left <= 0;
      holds_done     <= 0;
    end else if (long_hold_left > 0) begin
      out_ready      <= 1'b0;
      long_hold_left <= long_hold_left - 1;
    end else if (holds_done < 2 && n_in >= (holds_done == 0 ? 60 : 900)) begin
      out_ready      <= 1'b0;
      long_hold_left <= LONG_HOLD - 1;
      holds_done     <= holds_done + 1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_out <= n_out + 1;
      if (expected_replies.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10)
          $display("unexpected result: handle %0h source %0h status %0d",
                   result_handle, result_source, status);
      end else begin
        want = expected_replies.pop_front();
        if (want.hnd !== result_handle || want.src !== result_source ||
            want.st !== status) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("mismatch on result %0d: handle %0h/%0h source %0h/%0h status %0d/%0d",
                     n_out, want.hnd, result_handle, want.src, result_source,
                     want.st, status);
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    int h;
    for (int i = 0; i < hta_pkg::NUM_HANDLES; i++) begin
      used_map[i] = 1'b0;
      bound_word[i] = '0;
      gen_used[i] = 1'b0;
    end
    for (int g = 0; g < hta_pkg::NUM_GROUPS; g++) group_free[g] = 1'b1;
    gen_count = 0;
    errors = 0;
    n_grant = 0;
    n_full = 0;
    n_bad = 0;
    n_out = 0;
    stuck = 0;

    // directed: free handles, fresh grant, set to zero and all ones, reuse, out of range
    add_cmd(hta_pkg::OP_GET, 0, '0);
    add_cmd(hta_pkg::OP_GIVE, 0, '0);
    add_cmd(hta_pkg::OP_SET, 0, 32'h1234_5678);
    add_cmd(hta_pkg::OP_TAKE, 65535, '1);
    add_cmd(hta_pkg::OP_GET, 0, '0);
    add_cmd(hta_pkg::OP_SET, 0, '0);
    add_cmd(hta_pkg::OP_GET, 0, '1);
    add_cmd(hta_pkg::OP_SET, 0, '1);
    add_cmd(hta_pkg::OP_GET, 0, '0);
    add_cmd(hta_pkg::OP_TAKE, 0, '0);
    add_cmd(hta_pkg::OP_SET, 1, 32'hA5A5_5A5A);
    add_cmd(hta_pkg::OP_GET, 1, '0);
    add_cmd(hta_pkg::OP_GIVE, 0, '0);
    add_cmd(hta_pkg::OP_GIVE, 0, '0);
    add_cmd(hta_pkg::OP_GET, 0, '0);
    add_cmd(hta_pkg::OP_TAKE, 1, '0);
    add_cmd(hta_pkg::OP_GET, hta_pkg::NUM_HANDLES, '0);
    add_cmd(hta_pkg::OP_SET, 65535, '1);
    add_cmd(hta_pkg::OP_GIVE, hta_pkg::NUM_HANDLES, '0);
    add_cmd(hta_pkg::OP_GET, 16'h8000, '0);
    add_cmd(hta_pkg::OP_GET, hta_pkg::NUM_HANDLES - 1, '0);
    add_cmd(hta_pkg::OP_GIVE, 1, '0);
    add_cmd(hta_pkg::OP_GIVE, 0, '0);

    // random churn at low occupancy
    repeat (20) random_cmd(35, 20);
    // fill the table
    while (gen_count < hta_pkg::NUM_HANDLES) random_cmd(98, 1);
    // full table: refused takes, top handle, one slot freed and regranted
    repeat (4) add_cmd(hta_pkg::OP_TAKE, $urandom_range(0, 65535), pick_word());
    add_cmd(hta_pkg::OP_SET, hta_pkg::NUM_HANDLES - 1, pick_word());
    add_cmd(hta_pkg::OP_GET, hta_pkg::NUM_HANDLES - 1, '0);
    add_cmd(hta_pkg::OP_GET, hta_pkg::NUM_HANDLES, '0);
    h = pick_live();
    add_cmd(hta_pkg::OP_GIVE, h, '0);
    add_cmd(hta_pkg::OP_TAKE, 0, '0);
    add_cmd(hta_pkg::OP_GET, h, '0);
    add_cmd(hta_pkg::OP_TAKE, 0, '0);
    add_cmd(hta_pkg::OP_GIVE, hta_pkg::NUM_HANDLES - 1, '0);
    add_cmd(hta_pkg::OP_TAKE, 0, '0);
    add_cmd(hta_pkg::OP_GIVE, 0, '0);
    add_cmd(hta_pkg::OP_GIVE, 0, '0);
    add_cmd(hta_pkg::OP_TAKE, 0, '0);
    // mostly gives while draining
    repeat (20) random_cmd(10, 45);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // wait for the block to go quiet
    do @(negedge clk);
    while (queued_cmds.size() != 0 || in_valid || expected_replies.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_replies.size() != 0) begin
      errors = errors + expected_replies.size();
      $display("%0d results never arrived", expected_replies.size());
    end
    $display("%0d items in, %0d results checked", n_in, n_out);
    $display("%0d grants, %0d takes on a full table, %0d bad-handle replies",
             n_grant, n_full, n_bad);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/hta_pkg.sv
hw/rtl/handle_table_allocator.sv
tb/handle_table_allocator_tb.sv
